FILE: hdl/pfc_pkg.sv
// ----------------------------------------------------------------------------
// pfc_pkg
// Shared types and constants for the Playfair digraph cipher.
// ----------------------------------------------------------------------------
package pfc_pkg;

  localparam int LetterW  = 5;
  localparam int SqDim    = 5;
  localparam int RowW     = SqDim * LetterW;
  localparam int PosW     = 3;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = RowW;
  localparam int QDepth   = 4;
  localparam int QAddrW   = 2;

  typedef logic [LetterW-1:0]          letter_t;
  typedef logic [SqDim-1:0][RowW-1:0]  square_t;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_ROW0    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_ROW1    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_ROW2    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_ROW3    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_ROW4    = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_DECRYPT = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_FILLER  = 3'd6;

  // reset key square and filler (z)
  localparam logic [RowW-1:0] ROW0_RST = 25'd4294688;
  localparam logic [RowW-1:0] ROW1_RST = 25'd10755269;
  localparam logic [RowW-1:0] ROW2_RST = 25'd16201099;
  localparam logic [RowW-1:0] ROW3_RST = 25'd21613104;
  localparam logic [RowW-1:0] ROW4_RST = 25'd27025109;
  localparam letter_t         FILLER_RST = 5'd25;

  typedef struct packed {
    letter_t a;
    letter_t b;
    logic    last;
  } pair_t;

endpackage

FILE: hdl/pfc_ifs.sv
// ----------------------------------------------------------------------------
// pfc_ifs
// Valid/ready channels for letters in and digraphs out.
// ----------------------------------------------------------------------------
interface pfc_in_if;
  import pfc_pkg::*;
  logic    valid;
  logic    ready;
  letter_t letter;
  logic    last_in;
  modport source (output valid, output letter, output last_in, input ready);
  modport sink   (input valid, input letter, input last_in, output ready);
endinterface

interface pfc_out_if;
  import pfc_pkg::*;
  logic    valid;
  logic    ready;
  letter_t first_out;
  letter_t second_out;
  logic    unmatched;
  logic    last_out;
  modport source (output valid, output first_out, output second_out,
                  output unmatched, output last_out, input ready);
  modport sink   (input valid, input first_out, input second_out,
                  input unmatched, input last_out, output ready);
endinterface

FILE: hdl/pfc_front.sv
// ----------------------------------------------------------------------------
// pfc_front
// Groups incoming letters into digraphs, inserting the filler letter.
// ----------------------------------------------------------------------------
module pfc_front import pfc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  pfc_in_if.sink  letters,
  input  letter_t filler,
  output logic    push_valid,
  input  logic    push_ready,
  output pair_t   push_data
);

  logic    pend_valid;
  letter_t pend_letter;
  logic    extra;
  letter_t extra_letter;
  logic    accept;
  logic    produce;
  logic    same;

  assign letters.ready = !extra && push_ready;
  assign accept        = letters.valid && letters.ready;
  assign same          = pend_valid && (pend_letter == letters.letter);
  assign produce       = pend_valid || letters.last_in;

  always_comb begin
    push_valid = extra || (letters.valid && !extra && produce);
    push_data  = '{a: letters.letter, b: filler, last: 1'b1};
    if (extra) begin
      push_data = '{a: extra_letter, b: filler, last: 1'b1};
    end else if (pend_valid && !same) begin
      push_data = '{a: pend_letter, b: letters.letter, last: letters.last_in};
    end else if (same) begin
      push_data = '{a: pend_letter, b: filler, last: 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid  <= 1'b0;
      pend_letter <= '0;
      extra       <= 1'b0;
    end else begin
      if (extra && push_ready) begin
        extra <= 1'b0;
      end
      if (accept) begin
        if (!pend_valid) begin
          pend_valid  <= !letters.last_in;
          pend_letter <= letters.letter;
        end else if (!same) begin
          pend_valid <= 1'b0;
        end else if (letters.last_in) begin
          // doubled final letter: second digraph is held in extra and pushed when the queue is ready
          pend_valid   <= 1'b0;
          extra        <= 1'b1;
          extra_letter <= letters.letter;
        end
      end
    end
  end

endmodule

FILE: hdl/pfc_queue.sv
// ----------------------------------------------------------------------------
// pfc_queue
// Small FIFO of digraphs between pairing and cipher lookup.
// ----------------------------------------------------------------------------
module pfc_queue import pfc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  output logic  push_ready,
  input  pair_t push_data,
  output logic  pop_valid,
  input  logic  pop_ready,
  output pair_t pop_data
);

  pair_t             mem [QDepth];
  logic [QAddrW-1:0] wr_ptr;
  logic [QAddrW-1:0] rd_ptr;
  logic [QAddrW:0]   count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != QAddrW'(0) + (QAddrW+1)'(QDepth));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: hdl/pfc_back.sv
// ----------------------------------------------------------------------------
// pfc_back
// Two-stage cipher: locate both letters in the square, then pick the
// substituted cells into the output register.
// ----------------------------------------------------------------------------
module pfc_back import pfc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  square_t square,
  input  logic    decrypt,
  input  logic    pop_valid,
  output logic    pop_ready,
  input  pair_t   pop_data,
  pfc_out_if.source digraphs
);

  typedef struct packed {
    logic            found;
    logic [PosW-1:0] row;
    logic [PosW-1:0] col;
  } loc_t;

  // lowest cell in row-major order wins
  function automatic loc_t locate(letter_t code, square_t sq);
    loc_t l;
    l = '{found: 1'b0, row: '0, col: '0};
    for (int r = SqDim - 1; r >= 0; r--) begin
      for (int c = SqDim - 1; c >= 0; c--) begin
        if (sq[r][c*LetterW +: LetterW] == code) begin
          l = '{found: 1'b1, row: PosW'(r), col: PosW'(c)};
        end
      end
    end
    return l;
  endfunction

  function automatic logic [PosW-1:0] step(logic [PosW-1:0] x, logic back);
    logic [PosW-1:0] y;
    if (back) begin
      y = (x == '0) ? PosW'(SqDim - 1) : x - 1'b1;
    end else begin
      y = (x == PosW'(SqDim - 1)) ? '0 : x + 1'b1;
    end
    return y;
  endfunction

  function automatic letter_t sq_cell(square_t sq, logic [PosW-1:0] r,
                                      logic [PosW-1:0] c);
    letter_t v;
    v = '0;
    for (int i = 0; i < SqDim; i++) begin
      for (int k = 0; k < SqDim; k++) begin
        if (r == PosW'(i) && c == PosW'(k)) begin
          v = sq[i][k*LetterW +: LetterW];
        end
      end
    end
    return v;
  endfunction

  logic    s1_valid;
  pair_t   s1_pair;
  loc_t    s1_la;
  loc_t    s1_lb;
  logic    s1_adv;
  logic    s2_adv;
  letter_t oa;
  letter_t ob;
  logic    miss;

  assign s2_adv    = !digraphs.valid || digraphs.ready;
  assign s1_adv    = !s1_valid || s2_adv;
  assign pop_ready = s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_adv) begin
      s1_valid <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_pair <= pop_data;
      s1_la   <= locate(pop_data.a, square);
      s1_lb   <= locate(pop_data.b, square);
    end
  end

  always_comb begin
    oa   = s1_pair.a;
    ob   = s1_pair.b;
    miss = 1'b0;
    if (!s1_la.found || !s1_lb.found) begin
      miss = 1'b1;
    end else if (s1_la.row == s1_lb.row) begin
      oa = sq_cell(square, s1_la.row, step(s1_la.col, decrypt));
      ob = sq_cell(square, s1_lb.row, step(s1_lb.col, decrypt));
    end else if (s1_la.col == s1_lb.col) begin
      oa = sq_cell(square, step(s1_la.row, decrypt), s1_la.col);
      ob = sq_cell(square, step(s1_lb.row, decrypt), s1_lb.col);
    end else begin
      oa = sq_cell(square, s1_la.row, s1_lb.col);
      ob = sq_cell(square, s1_lb.row, s1_la.col);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digraphs.valid <= 1'b0;
    end else if (s2_adv) begin
      digraphs.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s1_valid) begin
      digraphs.first_out  <= oa;
      digraphs.second_out <= ob;
      digraphs.unmatched  <= miss;
      digraphs.last_out   <= s1_pair.last;
    end
  end

endmodule

FILE: hdl/playfair_digraph_cipher.sv
// ----------------------------------------------------------------------------
// playfair_digraph_cipher
// Playfair cipher over a letter stream against a configurable 5x5 key square.
//
//   channel    dir  payload                                      handshake
//   letters    in   letter[4:0], last_in                         valid/ready
//   digraphs   out  first_out, second_out, unmatched, last_out   valid/ready
//   wr_*       in   wr_index[2:0], wr_data[24:0]                 wr_en, no wait
//
// One letter per cycle while the queue has room; a doubled final letter
// holds off input while its second digraph enters the queue.
// The digraph a letter completes is written into the queue as the letter is
// accepted, then passes the locate stage and the output register.
// A 4-entry queue decouples pairing from lookup; either side may stall.
// Synchronous reset loads the default square, encipher mode and filler z.
// ----------------------------------------------------------------------------
module playfair_digraph_cipher import pfc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  pfc_in_if.sink              letters,
  pfc_out_if.source           digraphs,
  input  logic                wr_en,
  input  logic [CfgIdxW-1:0]  wr_index,
  input  logic [CfgDataW-1:0] wr_data
);

  square_t square;
  logic    decrypt;
  letter_t filler;
  logic    push_valid;
  logic    push_ready;
  pair_t   push_data;
  logic    pop_valid;
  logic    pop_ready;
  pair_t   pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      square[0] <= ROW0_RST;
      square[1] <= ROW1_RST;
      square[2] <= ROW2_RST;
      square[3] <= ROW3_RST;
      square[4] <= ROW4_RST;
      decrypt   <= 1'b0;
      filler    <= FILLER_RST;
    end else if (wr_en) begin
      unique case (wr_index) inside
        REG_ROW0, REG_ROW1, REG_ROW2, REG_ROW3, REG_ROW4: begin
          square[wr_index] <= wr_data[RowW-1:0];
        end
        REG_DECRYPT: decrypt <= wr_data[0];
        REG_FILLER:  filler  <= wr_data[LetterW-1:0];
        default: ;
      endcase
    end
  end

  pfc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .letters    (letters),
    .filler     (filler),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  pfc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  pfc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .square    (square),
    .decrypt   (decrypt),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .digraphs  (digraphs)
  );

endmodule
